// ===== rtl/cdq_pkg.sv =====
`default_nettype none

package cdq_pkg;

   // queue geometry
   localparam int Depth     = 8;
   localparam int DataWidth = 32;
   localparam int PtrWidth  = (Depth > 1) ? $clog2(Depth) : 1;

   typedef logic [PtrWidth-1:0]         ptr_type;
   typedef logic signed [DataWidth-1:0] word_type;

   // operation codes on the request channel
   typedef enum logic [1:0] {
      OP_INSERT_FRONT = 2'd0,
      OP_INSERT_REAR  = 2'd1,
      OP_REMOVE_FRONT = 2'd2,
      OP_REMOVE_REAR  = 2'd3
   } op_type;

   // result status codes
   typedef enum logic [1:0] {
      STATUS_DONE      = 2'd0,
      STATUS_OVERFLOW  = 2'd1,
      STATUS_UNDERFLOW = 2'd2
   } status_type;

   // controller sequence
   typedef enum logic [1:0] {
      STATE_IDLE,
      STATE_EXEC,
      STATE_READ,
      STATE_RESP
   } state_type;

   // commands from controller to datapath
   typedef struct packed {
      logic latch;
      logic exec;
      logic read;
   } cmd_type;

   // ring index helpers
   function automatic ptr_type idx_next(input ptr_type i);
      return (i == ptr_type'(Depth - 1)) ? '0 : ptr_type'(i + 1'b1);
   endfunction

   function automatic ptr_type idx_prev(input ptr_type i);
      return (i == '0) ? ptr_type'(Depth - 1) : ptr_type'(i - 1'b1);
   endfunction

endpackage

`default_nettype wire

// ===== rtl/circular_deque.sv =====
`default_nettype none

// Double-ended queue of eight signed 32-bit words held in a ring store. Each item
// on req_ is one operation (insert front, insert rear, remove front, remove rear),
// taken when start is high and busy is low. Exactly one result follows for each
// item, three cycles after acceptance: rsp_valid is high for a single cycle and
// the receiver cannot stall, so the result must be captured in that cycle. One
// item takes four cycles: accept, pointer update with the store write, a
// registered read of both ends from the store, then the result strobe; busy
// stays high from the cycle after accept through the strobe. Inserting while full
// reports overflow and removing while empty reports underflow, both with no
// change; front and rear values read as zero while the queue is empty.
module circular_deque (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              start,
   output logic                   busy,
   input  wire logic [1:0]        req_operation,
   input  wire cdq_pkg::word_type req_value,
   output logic                   rsp_valid,
   output logic [1:0]             rsp_status,
   output logic                   rsp_is_empty,
   output logic                   rsp_is_full,
   output cdq_pkg::word_type      rsp_front_value,
   output cdq_pkg::word_type      rsp_rear_value
);
   import cdq_pkg::*;

   cmd_type cmd;

   // sequencing
   cdq_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .rsp_valid (rsp_valid),
      .cmd       (cmd)
   );

   // pointers, store and result fields
   cdq_datapath u_datapath (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .req_operation   (req_operation),
      .req_value       (req_value),
      .rsp_status      (rsp_status),
      .rsp_is_empty    (rsp_is_empty),
      .rsp_is_full     (rsp_is_full),
      .rsp_front_value (rsp_front_value),
      .rsp_rear_value  (rsp_rear_value)
   );

endmodule

`default_nettype wire

// ===== rtl/cdq_ctrl.sv =====
`default_nettype none

module cdq_ctrl (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             start,
   output logic                  busy,
   output logic                  rsp_valid,
   output cdq_pkg::cmd_type      cmd
);
   import cdq_pkg::*;

   state_type state_ff;
   state_type state_in;

   // state register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= STATE_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // next state and commands
   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      busy      = 1'b1;
      rsp_valid = 1'b0;
      case (state_ff)
         STATE_IDLE: begin
            busy = 1'b0;
            if (start) begin
               cmd.latch = 1'b1;
               state_in  = STATE_EXEC;
            end
         end
         STATE_EXEC: begin
            cmd.exec = 1'b1;
            state_in = STATE_READ;
         end
         STATE_READ: begin
            cmd.read = 1'b1;
            state_in = STATE_RESP;
         end
         STATE_RESP: begin
            rsp_valid = 1'b1;
            state_in  = STATE_IDLE;
         end
         default: begin
            state_in = STATE_IDLE;
         end
      endcase
   end

   // an accepted item always runs the full sequence to one strobe
   a_accept_exec: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> cmd.exec) else $error("accepted item not executed");
   a_read_then_resp: assert property (@(posedge clock) disable iff (reset)
      cmd.read |=> (rsp_valid && busy)) else $error("read not followed by result");
   a_single_strobe: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid && !busy) else $error("result strobe held");

endmodule

`default_nettype wire

// ===== rtl/cdq_datapath.sv =====
`default_nettype none

module cdq_datapath (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire cdq_pkg::cmd_type  cmd,
   input  wire logic [1:0]        req_operation,
   input  wire cdq_pkg::word_type req_value,
   output logic [1:0]             rsp_status,
   output logic                   rsp_is_empty,
   output logic                   rsp_is_full,
   output cdq_pkg::word_type      rsp_front_value,
   output cdq_pkg::word_type      rsp_rear_value
);
   import cdq_pkg::*;

   word_type   ring_ff [Depth];
   op_type     op_ff;
   word_type   value_ff;
   status_type status_ff;
   status_type status_in;
   ptr_type    head_ff;
   ptr_type    head_in;
   ptr_type    tail_ff;
   ptr_type    tail_in;
   logic       empty_ff;
   logic       empty_in;
   word_type   front_rd_ff;
   word_type   rear_rd_ff;
   logic       full;
   logic       wr_en;
   ptr_type    wr_addr;

   assign full = !empty_ff && (idx_next(tail_ff) == head_ff);

   // item capture at accept
   always_ff @(posedge clock) begin
      if (cmd.latch) begin
         op_ff    <= op_type'(req_operation);
         value_ff <= req_value;
      end
   end

   // pointer update and store write for one operation
   always_comb begin
      head_in   = head_ff;
      tail_in   = tail_ff;
      empty_in  = empty_ff;
      status_in = STATUS_DONE;
      wr_en     = 1'b0;
      wr_addr   = '0;
      case (op_ff)
         OP_INSERT_FRONT, OP_INSERT_REAR: begin
            if (full) begin
               status_in = STATUS_OVERFLOW;
            end else if (empty_ff) begin
               head_in  = '0;
               tail_in  = '0;
               empty_in = 1'b0;
               wr_en    = 1'b1;
               wr_addr  = '0;
            end else if (op_ff == OP_INSERT_FRONT) begin
               head_in = idx_prev(head_ff);
               wr_en   = 1'b1;
               wr_addr = idx_prev(head_ff);
            end else begin
               tail_in = idx_next(tail_ff);
               wr_en   = 1'b1;
               wr_addr = idx_next(tail_ff);
            end
         end
         OP_REMOVE_FRONT, OP_REMOVE_REAR: begin
            if (empty_ff) begin
               status_in = STATUS_UNDERFLOW;
            end else if (head_ff == tail_ff) begin
               // last entry leaves, both ends back to slot zero
               empty_in = 1'b1;
               head_in  = '0;
               tail_in  = '0;
            end else if (op_ff == OP_REMOVE_FRONT) begin
               head_in = idx_next(head_ff);
            end else begin
               tail_in = idx_prev(tail_ff);
            end
         end
         default: begin
            status_in = STATUS_DONE;
         end
      endcase
   end

   // queue control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff  <= '0;
         tail_ff  <= '0;
         empty_ff <= 1'b1;
      end else if (cmd.exec) begin
         head_ff  <= head_in;
         tail_ff  <= tail_in;
         empty_ff <= empty_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.exec) begin
         status_ff <= status_in;
      end
   end

   // ring store, one write port and two registered read ports
   always_ff @(posedge clock) begin
      if (cmd.exec && wr_en) begin
         ring_ff[wr_addr] <= value_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.read) begin
         front_rd_ff <= ring_ff[head_ff];
         rear_rd_ff  <= ring_ff[tail_ff];
      end
   end

   // result fields
   assign rsp_status      = status_ff;
   assign rsp_is_empty    = empty_ff;
   assign rsp_is_full     = full;
   assign rsp_front_value = empty_ff ? '0 : front_rd_ff;
   assign rsp_rear_value  = empty_ff ? '0 : rear_rd_ff;

   // an empty queue always sits with both ends at slot zero
   a_empty_at_zero: assert property (@(posedge clock) disable iff (reset)
      empty_ff |-> (head_ff == '0 && tail_ff == '0)) else $error("empty queue off slot zero");
   // a refused insert leaves the ends where they were
   a_overflow_hold: assert property (@(posedge clock) disable iff (reset)
      (cmd.exec && full && (op_ff == OP_INSERT_FRONT || op_ff == OP_INSERT_REAR))
      |=> ($stable(head_ff) && $stable(tail_ff) && !empty_ff))
      else $error("overflow changed queue");

endmodule

`default_nettype wire
